[design/sbs_pkg.sv]
// ----------------------------------------------------------------------------
// sbs_pkg
// Shared types and constants for the sorted table bound search unit.
// ----------------------------------------------------------------------------
package sbs_pkg;

   localparam int unsigned DEFAULT_TABLE_DEPTH = 256;

   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned INDEX_W  = 8;
   localparam int unsigned COUNT_W  = 9;
   localparam int unsigned MODE_W   = 2;

   localparam logic [COUNT_W-1:0] ENTRY_COUNT_RESET = 9'd1;

   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   typedef struct packed {
      logic                       action;
      logic        [INDEX_W-1:0]  entry_index;
      logic signed [VALUE_W-1:0]  entry_value;
      logic signed [VALUE_W-1:0]  search_key;
      logic        [MODE_W-1:0]   bound_mode;
   } sbs_req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0]  found_value;
      logic        [INDEX_W-1:0]  found_index;
   } sbs_rsp_type;

   typedef enum logic [1:0] {
      SBS_IDLE,
      SBS_PROBE,
      SBS_COMPARE,
      SBS_DONE
   } sbs_state_type;

   typedef struct packed {
      logic load_query;
      logic write_entry;
      logic step;
   } sbs_cmd_type;

   typedef struct packed {
      logic lo_lt_hi;
   } sbs_status_type;

endpackage

[design/sorted_table_bound_search_unit.sv]
// ----------------------------------------------------------------------------
// sorted_table_bound_search_unit
// Binary search over a table of signed entries kept in ascending order.
//
// req channel: a beat is taken at a clock edge with start high and busy low.
//   action write stores entry_value at entry_index, with no result, and
//   busy stays low. action query searches the first entry_count entries.
// rsp channel: rsp_valid is high for exactly one cycle with found_value and
//   found_index; the receiver cannot stall, so nothing is held back.
// csr port: csr_we with csr_wdata loads entry_count (reset value 1).
// probes: a query needs P probes (P = ceil(log2 n) or one less, n the entry
//   count clamped to 1..TABLE_DEPTH); each probe is one table read plus one
//   compare, the table having a single registered read port.
// overlap: a new beat can be taken in the result cycle, not while a query
//   is busy.
// reset: the count returns to 1 and the sequencer to idle; table contents
//   are undefined until written.
// ----------------------------------------------------------------------------
module sorted_table_bound_search_unit #(
   parameter int unsigned TABLE_DEPTH = sbs_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  sbs_pkg::sbs_req_type        req_data,
   output logic                        rsp_valid,
   output sbs_pkg::sbs_rsp_type        rsp_data,
   input  logic                        csr_we,
   input  logic [sbs_pkg::COUNT_W-1:0] csr_wdata
);

   sbs_pkg::sbs_cmd_type    cmd;
   sbs_pkg::sbs_status_type status;

   sbs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_action (req_data.action),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_valid  (rsp_valid)
   );

   sbs_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule

[design/sbs_ram.sv]
// ----------------------------------------------------------------------------
// sbs_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module sbs_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 256,
   parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/sbs_ctrl.sv]
// ----------------------------------------------------------------------------
// sbs_ctrl
// Sequencer for the bound search: accepts beats, steps the probe loop and
// raises the result strobe.
// ----------------------------------------------------------------------------
module sbs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   req_action,
   input  sbs_pkg::sbs_status_type status,
   output sbs_pkg::sbs_cmd_type   cmd,
   output logic                   busy,
   output logic                   rsp_valid
);

   sbs_pkg::sbs_state_type state_ff;
   sbs_pkg::sbs_state_type state_in;
   logic                   accept;

   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sbs_pkg::SBS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sbs_pkg::SBS_IDLE, sbs_pkg::SBS_DONE: begin
            if (accept && req_action == sbs_pkg::ACT_QUERY) begin
               state_in = sbs_pkg::SBS_PROBE;
            end else begin
               state_in = sbs_pkg::SBS_IDLE;
            end
         end
         sbs_pkg::SBS_PROBE: begin
            if (status.lo_lt_hi) begin
               state_in = sbs_pkg::SBS_COMPARE;
            end else begin
               state_in = sbs_pkg::SBS_DONE;
            end
         end
         sbs_pkg::SBS_COMPARE: begin
            state_in = sbs_pkg::SBS_PROBE;
         end
         default: begin
            state_in = sbs_pkg::SBS_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      busy             = 1'b0;
      rsp_valid        = 1'b0;
      cmd.step         = 1'b0;
      cmd.load_query   = 1'b0;
      cmd.write_entry  = 1'b0;
      case (state_ff)
         sbs_pkg::SBS_IDLE: begin
            cmd.load_query  = start && req_action == sbs_pkg::ACT_QUERY;
            cmd.write_entry = start && req_action == sbs_pkg::ACT_WRITE;
         end
         sbs_pkg::SBS_DONE: begin
            rsp_valid       = 1'b1;
            cmd.load_query  = start && req_action == sbs_pkg::ACT_QUERY;
            cmd.write_entry = start && req_action == sbs_pkg::ACT_WRITE;
         end
         sbs_pkg::SBS_PROBE: begin
            busy = 1'b1;
         end
         sbs_pkg::SBS_COMPARE: begin
            busy     = 1'b1;
            cmd.step = 1'b1;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

endmodule

[design/sbs_dp.sv]
// ----------------------------------------------------------------------------
// sbs_dp
// Datapath for the bound search: entry table, count register, search bounds
// and the probe compare.
// ----------------------------------------------------------------------------
module sbs_dp #(
   parameter int unsigned TABLE_DEPTH = sbs_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  sbs_pkg::sbs_req_type          req_data,
   input  logic                          csr_we,
   input  logic [sbs_pkg::COUNT_W-1:0]   csr_wdata,
   input  sbs_pkg::sbs_cmd_type          cmd,
   output sbs_pkg::sbs_status_type       status,
   output sbs_pkg::sbs_rsp_type          rsp_data
);

   localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam int unsigned EW    = (CNT_W > sbs_pkg::COUNT_W) ? CNT_W : sbs_pkg::COUNT_W;
   localparam int unsigned PW    = ((IDX_W > sbs_pkg::INDEX_W) ? IDX_W : sbs_pkg::INDEX_W) + 1;
   localparam int unsigned MW    = IDX_W + 1;

   logic [sbs_pkg::COUNT_W-1:0]       entry_count_ff;
   logic [IDX_W-1:0]                  lo_ff;
   logic [IDX_W-1:0]                  lo_in;
   logic [IDX_W-1:0]                  hi_ff;
   logic [IDX_W-1:0]                  hi_in;
   logic [IDX_W-1:0]                  mid_ff;
   logic [IDX_W-1:0]                  mid;
   logic [MW-1:0]                     mid_sum;
   logic signed [sbs_pkg::VALUE_W-1:0] key_ff;
   logic [sbs_pkg::MODE_W-1:0]        mode_ff;
   logic [EW-1:0]                     count_x;
   logic [EW-1:0]                     count_n;
   logic [EW-1:0]                     hi_init;
   logic                              upward;
   logic                              qualifies;
   logic signed [sbs_pkg::VALUE_W-1:0] entry;
   logic                              wr_in_range;
   logic                              wr_en;
   logic [IDX_W-1:0]                  rd_addr;
   logic [sbs_pkg::VALUE_W-1:0]       rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= sbs_pkg::ENTRY_COUNT_RESET;
      end else if (csr_we) begin
         entry_count_ff <= csr_wdata;
      end
   end

   // clamp the count to 1..TABLE_DEPTH
   always_comb begin
      count_x = EW'(entry_count_ff);
      if (count_x == '0) begin
         count_n = EW'(1);
      end else if (count_x > EW'(TABLE_DEPTH)) begin
         count_n = EW'(TABLE_DEPTH);
      end else begin
         count_n = count_x;
      end
      hi_init = count_n - EW'(1);
   end

   assign upward  = !mode_ff[1];
   assign mid_sum = MW'(lo_ff) + MW'(hi_ff) + MW'(upward);
   assign mid     = mid_sum[IDX_W:1];

   assign entry     = $signed(rd_data);
   assign qualifies = mode_ff[0] ? (entry <= key_ff) : (entry < key_ff);

   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      if (cmd.load_query) begin
         lo_in = '0;
         hi_in = hi_init[IDX_W-1:0];
      end else if (cmd.step) begin
         if (upward) begin
            if (qualifies) begin
               lo_in = mid_ff;
            end else begin
               hi_in = mid_ff - IDX_W'(1);
            end
         end else begin
            if (qualifies) begin
               lo_in = mid_ff + IDX_W'(1);
            end else begin
               hi_in = mid_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      mid_ff <= mid;
      if (cmd.load_query) begin
         key_ff  <= req_data.search_key;
         mode_ff <= req_data.bound_mode;
      end
   end

   assign status.lo_lt_hi = lo_ff < hi_ff;
   assign rd_addr         = status.lo_lt_hi ? mid : lo_ff;

   assign wr_in_range = PW'(req_data.entry_index) < PW'(TABLE_DEPTH);
   assign wr_en       = cmd.write_entry && wr_in_range;

   sbs_ram #(
      .WIDTH (sbs_pkg::VALUE_W),
      .DEPTH (TABLE_DEPTH),
      .AW    (IDX_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (IDX_W'(req_data.entry_index)),
      .wr_data (req_data.entry_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rsp_data.found_value = entry;
   assign rsp_data.found_index = sbs_pkg::INDEX_W'(lo_ff);

endmodule

[design/sbs_chk.sv]
// ----------------------------------------------------------------------------
// sbs_chk
// Port-level checks for the sorted table bound search unit.
// ----------------------------------------------------------------------------
module sbs_chk (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input sbs_pkg::sbs_req_type        req_data,
   input logic                        rsp_valid
);

   // one result beat per query, never back to back
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("rsp_valid held for two cycles");

   // a result closes a busy search
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy) && !busy)
      else $error("result without a preceding search");

   // an accepted write finishes at once
   a_write_no_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.action == sbs_pkg::ACT_WRITE) |=> !busy && !rsp_valid)
      else $error("write beat caused busy or a result");

   // an accepted query starts a search
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.action == sbs_pkg::ACT_QUERY) |=> busy && !rsp_valid)
      else $error("query beat did not start a search");

endmodule

bind sorted_table_bound_search_unit sbs_chk u_sbs_chk (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_data  (req_data),
   .rsp_valid (rsp_valid)
);

[bench/sorted_table_bound_search_unit_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_table_bound_search_unit_test
// Self-checking bench for the sorted table bound search unit. A scoreboard
// keeps its own copy of the table and the entry count and runs the same
// binary search for every query beat it sees taken. Each strobed result is
// compared field by field against the oldest predicted result. Stimulus
// fills the table in ascending order, runs directed boundary queries, then
// random phases over many entry counts with stray writes mixed in.
// ----------------------------------------------------------------------------
module sorted_table_bound_search_unit_test;
   import sbs_pkg::*;

   localparam logic [MODE_W-1:0] MODE_BELOW       = 2'd0;
   localparam logic [MODE_W-1:0] MODE_AT_OR_BELOW = 2'd1;
   localparam logic [MODE_W-1:0] MODE_AT_OR_ABOVE = 2'd2;
   localparam logic [MODE_W-1:0] MODE_ABOVE       = 2'd3;

   localparam int unsigned TABLE_SIZE    = DEFAULT_TABLE_DEPTH;
   localparam int unsigned BEAT_TARGET   = 1300;
   localparam int unsigned SETTLE_CYCLES = 24;
   localparam int unsigned MAX_GAP       = 40;
   localparam int unsigned QUIET_LIMIT   = 4000;

   localparam longint VALUE_MIN = -64'sd2147483648;
   localparam longint VALUE_MAX = 64'sd2147483647;

   localparam logic signed [VALUE_W-1:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] KEY_MAX = 32'sh7fff_ffff;

   class sbs_scoreboard;
      logic signed [VALUE_W-1:0] entries [TABLE_SIZE];
      logic [COUNT_W-1:0]        entry_count;
      sbs_rsp_type               expected_q [$];
      int unsigned               mismatches;

      function new();
         foreach (entries[i]) entries[i] = '0;
         entry_count = ENTRY_COUNT_RESET;
         mismatches  = 0;
      endfunction

      function int unsigned active_entries();
         int unsigned n;
         n = 32'(entry_count);
         if (n == 0) n = 1;
         if (n > TABLE_SIZE) n = TABLE_SIZE;
         return n;
      endfunction

      function sbs_rsp_type search_bound(logic signed [VALUE_W-1:0] key,
                                         logic [MODE_W-1:0] mode);
         int unsigned lo, hi, mid;
         logic signed [VALUE_W-1:0] probe;
         logic go_right;
         sbs_rsp_type r;
         lo = 0;
         hi = active_entries() - 1;
         while (lo < hi) begin
            if (mode == MODE_BELOW || mode == MODE_AT_OR_BELOW) begin
               mid = (lo + hi + 1) >> 1;
               probe = entries[mid[INDEX_W-1:0]];
               go_right = (mode == MODE_BELOW) ? (probe < key) : (probe <= key);
               if (go_right) lo = mid;
               else hi = mid - 1;
            end else begin
               mid = (lo + hi) >> 1;
               probe = entries[mid[INDEX_W-1:0]];
               go_right = (mode == MODE_AT_OR_ABOVE) ? (probe < key) : (probe <= key);
               if (go_right) lo = mid + 1;
               else hi = mid;
            end
         end
         r.found_value = entries[lo[INDEX_W-1:0]];
         r.found_index = lo[INDEX_W-1:0];
         return r;
      endfunction

      function void note_beat(sbs_req_type beat);
         if (beat.action == ACT_WRITE) begin
            entries[beat.entry_index] = beat.entry_value;
         end else begin
            expected_q.push_back(search_bound(beat.search_key, beat.bound_mode));
         end
      endfunction

      task report_mismatch(string what);
         $display("%0t: %s", $time, what);
         mismatches++;
      endtask

      task check_result(sbs_rsp_type got);
         sbs_rsp_type want;
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("result with nothing pending: value %0d index %0d",
                                      got.found_value, got.found_index));
         end else begin
            want = expected_q.pop_front();
            if (got.found_value !== want.found_value)
               report_mismatch($sformatf("found_value got %0d expected %0d",
                                         got.found_value, want.found_value));
            if (got.found_index !== want.found_index)
               report_mismatch($sformatf("found_index got %0d expected %0d",
                                         got.found_index, want.found_index));
         end
      endtask

      function int unsigned pending();
         return expected_q.size();
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   sbs_req_type        req_data;
   logic               rsp_valid;
   sbs_rsp_type        rsp_data;
   logic               csr_we;
   logic [COUNT_W-1:0] csr_wdata;

   sbs_scoreboard board = new();
   int unsigned   sent_beats;
   int unsigned   quiet_cycles;

   sorted_table_bound_search_unit dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) board.check_result(rsp_data);
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   function automatic int unsigned sender_idle_pct();
      if (sent_beats < BEAT_TARGET / 3) return 19;
      if (sent_beats < 2 * BEAT_TARGET / 3) return 84;
      return 0;
   endfunction

   function automatic sbs_req_type make_write(logic [INDEX_W-1:0] idx,
                                              logic [VALUE_W-1:0] val);
      sbs_req_type r;
      r.action      = ACT_WRITE;
      r.entry_index = idx;
      r.entry_value = val;
      r.search_key  = $urandom;
      r.bound_mode  = MODE_W'($urandom_range(0, 3));
      return r;
   endfunction

   function automatic sbs_req_type make_query(logic [VALUE_W-1:0] key,
                                              logic [MODE_W-1:0] mode);
      sbs_req_type r;
      r.action      = ACT_QUERY;
      r.entry_index = INDEX_W'($urandom_range(0, TABLE_SIZE - 1));
      r.entry_value = $urandom;
      r.search_key  = key;
      r.bound_mode  = mode;
      return r;
   endfunction

   // keys near stored entries hit exact matches and both neighbors
   function automatic logic signed [VALUE_W-1:0] pick_key();
      int unsigned roll;
      int unsigned pos;
      logic signed [VALUE_W-1:0] key;
      roll = $urandom_range(99);
      pos  = $urandom_range(0, board.active_entries() - 1);
      if (roll < 50) begin
         key = board.entries[pos[INDEX_W-1:0]];
         case ($urandom_range(2))
            0: key = key - 1;
            1: key = key + 1;
            default: key = board.entries[pos[INDEX_W-1:0]];
         endcase
      end else if (roll < 65) begin
         case ($urandom_range(3))
            0: key = KEY_MIN;
            1: key = KEY_MAX;
            2: key = '0;
            default: key = '1;
         endcase
      end else begin
         key = $urandom;
      end
      return key;
   endfunction

   task automatic send_beat(input sbs_req_type beat);
      int unsigned gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct()) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (busy);
      board.note_beat(beat);
      sent_beats++;
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_entry_count(input logic [COUNT_W-1:0] count);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= count;
      @(posedge clock);
      csr_we    <= 1'b0;
      board.entry_count = count;
   endtask

   // nondecreasing values from the low end, duplicates included
   task automatic fill_ascending(input int unsigned n);
      longint      level;
      int unsigned stride;
      stride = 32'hffff_ffff / (n + 1);
      level  = VALUE_MIN + $urandom_range(0, stride);
      for (int unsigned i = 0; i < n; i++) begin
         send_beat(make_write(i[INDEX_W-1:0], level[VALUE_W-1:0]));
         if ($urandom_range(3) == 0) level = level + $urandom_range(0, 2);
         else level = level + $urandom_range(0, 2 * stride);
         if (level > VALUE_MAX) level = VALUE_MAX;
      end
   endtask

   task automatic random_phase();
      int unsigned roll;
      int unsigned beats;
      logic [COUNT_W-1:0] count;
      roll = $urandom_range(99);
      if (roll < 60) count = COUNT_W'($urandom_range(1, 16));
      else if (roll < 75) count = COUNT_W'($urandom_range(17, 255));
      else if (roll < 85) count = COUNT_W'(TABLE_SIZE);
      else if (roll < 92) count = COUNT_W'($urandom_range(0, 1));
      else count = COUNT_W'($urandom_range(TABLE_SIZE + 1, 511));
      set_entry_count(count);
      if (board.active_entries() <= 32 || $urandom_range(9) == 0)
         fill_ascending(board.active_entries());
      beats = $urandom_range(15, 40);
      repeat (beats) begin
         if ($urandom_range(99) < 88)
            send_beat(make_query(pick_key(), MODE_W'($urandom_range(0, 3))));
         else
            send_beat(make_write(INDEX_W'($urandom_range(0, TABLE_SIZE - 1)), $urandom));
      end
   endtask

   initial begin
      logic signed [VALUE_W-1:0] mid_entry;
      sent_beats = 0;
      reset     <= 1'b1;
      start     <= 1'b0;
      req_data  <= '0;
      csr_we    <= 1'b0;
      csr_wdata <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // single-entry table at the reset count
      send_beat(make_write('0, '0));
      send_beat(make_query(-32'sd1, MODE_BELOW));
      send_beat(make_query('0, MODE_AT_OR_BELOW));
      send_beat(make_query('0, MODE_AT_OR_ABOVE));
      send_beat(make_query(32'sd1, MODE_ABOVE));

      fill_ascending(TABLE_SIZE);
      send_beat(make_write('0, KEY_MIN));
      send_beat(make_write(INDEX_W'(TABLE_SIZE - 1), KEY_MAX));

      // full table: boundaries, no qualifying entry, exact match
      set_entry_count(COUNT_W'(TABLE_SIZE));
      send_beat(make_query(KEY_MIN, MODE_BELOW));
      send_beat(make_query(KEY_MIN, MODE_AT_OR_BELOW));
      send_beat(make_query(KEY_MAX, MODE_AT_OR_ABOVE));
      send_beat(make_query(KEY_MAX, MODE_ABOVE));
      mid_entry = board.entries[8'd100];
      send_beat(make_query(mid_entry, MODE_BELOW));
      send_beat(make_query(mid_entry, MODE_AT_OR_BELOW));
      send_beat(make_query(mid_entry, MODE_AT_OR_ABOVE));
      send_beat(make_query(mid_entry, MODE_ABOVE));

      // count of zero acts as one, counts past the table saturate
      set_entry_count('0);
      send_beat(make_query(KEY_MAX, MODE_AT_OR_ABOVE));
      set_entry_count('1);
      send_beat(make_query(KEY_MAX, MODE_ABOVE));
      send_beat(make_query(KEY_MIN, MODE_AT_OR_BELOW));

      while (sent_beats < BEAT_TARGET) random_phase();

      wait_drained();
      if (board.mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

[sim.f]
design/sbs_pkg.sv
design/sbs_ram.sv
design/sbs_ctrl.sv
design/sbs_dp.sv
design/sorted_table_bound_search_unit.sv
design/sbs_chk.sv
bench/sorted_table_bound_search_unit_test.sv
